// ----- rtl/gtg_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gtg_pkg
// Shared types and constants of the go-to-goal controller.
// ----------------------------------------------------------------------------
package gtg_pkg;

    localparam int XW = 44;      // CORDIC x/y datapath width
    localparam int ZW = 20;      // CORDIC angle width, rad Q16

    localparam logic signed [ZW-1:0] PI_Q16      = 20'sd205887;
    localparam logic signed [ZW-1:0] TWO_PI_Q16  = 20'sd411775;
    localparam logic signed [ZW-1:0] HALF_PI_Q16 = 20'sd102944;
    localparam logic [15:0]          INV_K_Q16   = 16'd39797;
    localparam logic [16:0]          DIST_MAX    = 17'd131071;

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_ROT  = 2'd1;
    localparam logic [1:0] PH_MOVE = 2'd2;
    localparam logic [1:0] PH_DONE = 2'd3;

    localparam logic [2:0] CFG_GOAL_X  = 3'd0;
    localparam logic [2:0] CFG_GOAL_Y  = 3'd1;
    localparam logic [2:0] CFG_H_GAIN  = 3'd2;
    localparam logic [2:0] CFG_H_LIM   = 3'd3;
    localparam logic [2:0] CFG_H_TOL   = 3'd4;
    localparam logic [2:0] CFG_D_GAIN  = 3'd5;
    localparam logic [2:0] CFG_SPD_LIM = 3'd6;
    localparam logic [2:0] CFG_D_TOL   = 3'd7;

    typedef struct packed {
        logic load;     // capture word and start CORDIC
        logic post;     // run post-processing stage 1
        logic fin;      // run final stage, update state
    } gtg_cmd_t;

    typedef struct packed {
        logic cordic_done;
    } gtg_sts_t;

    function automatic logic signed [ZW-1:0] atan_q16(input logic [4:0] i);
        logic signed [ZW-1:0] r;
        begin
            unique case (i)
                5'd0:  r = 20'sd51472;
                5'd1:  r = 20'sd30386;
                5'd2:  r = 20'sd16055;
                5'd3:  r = 20'sd8150;
                5'd4:  r = 20'sd4091;
                5'd5:  r = 20'sd2047;
                5'd6:  r = 20'sd1024;
                5'd7:  r = 20'sd512;
                5'd8:  r = 20'sd256;
                5'd9:  r = 20'sd128;
                5'd10: r = 20'sd64;
                5'd11: r = 20'sd32;
                5'd12: r = 20'sd16;
                5'd13: r = 20'sd8;
                5'd14: r = 20'sd4;
                5'd15: r = 20'sd2;
                5'd16: r = 20'sd1;
                default: r = '0;
            endcase
            return r;
        end
    endfunction

endpackage
`default_nettype wire

// ----- rtl/gtg_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gtg_in_if / gtg_out_if
// Valid/ready channels for pose words and command words.
// ----------------------------------------------------------------------------
interface gtg_in_if;
    logic               valid;
    logic               ready;
    logic               start_goal;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [14:0] heading;
    modport source (output valid, start_goal, pos_x, pos_y, heading, input ready);
    modport sink   (input valid, start_goal, pos_x, pos_y, heading, output ready);
endinterface

interface gtg_out_if;
    logic               valid;
    logic               ready;
    logic [15:0]        linear_cmd;
    logic signed [15:0] angular_cmd;
    logic [1:0]         phase_now;
    logic               goal_reached;
    modport source (output valid, linear_cmd, angular_cmd, phase_now, goal_reached,
                    input ready);
    modport sink   (input valid, linear_cmd, angular_cmd, phase_now, goal_reached,
                    output ready);
endinterface
`default_nettype wire

// ----- rtl/gtg_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gtg_ctrl
// Sequencer: accept word, run CORDIC, post-process, hold result.
// ----------------------------------------------------------------------------
module gtg_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output gtg_pkg::gtg_cmd_t     cmd,
    input  wire gtg_pkg::gtg_sts_t sts
);
    import gtg_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_CORD = 5'b00010,
        S_POST = 5'b00100,
        S_FIN  = 5'b01000,
        S_OUT  = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_CORD;
                end
            end
            S_CORD:
                if (sts.cordic_done)
                    state_next = S_POST;
            S_POST:
            begin
                cmd.post   = 1'b1;
                state_next = S_FIN;
            end
            S_FIN:
            begin
                cmd.fin    = 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                out_valid = 1'b1;
                // next word may enter while the result is taken
                in_ready  = out_ready;
                if (out_ready)
                begin
                    if (in_valid)
                    begin
                        cmd.load   = 1'b1;
                        state_next = S_CORD;
                    end
                    else
                        state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    a_onehot: assert property (@(posedge clk) disable iff (!rst_n) $onehot(state_reg))
        else $error("state not one-hot");
    a_fin_after_post: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.post |=> cmd.fin) else $error("fin must follow post");
    a_out_after_fin: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.fin |=> out_valid) else $error("result must follow fin");
endmodule
`default_nettype wire

// ----- rtl/gtg_dp.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gtg_dp
// Datapath: registers, shared vectoring CORDIC, control law and phase state.
// ----------------------------------------------------------------------------
module gtg_dp #(
    parameter int ITER = 16
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_we,
    input  wire logic [2:0]         cfg_index,
    input  wire logic [15:0]        cfg_data,
    input  wire logic               start_goal,
    input  wire logic signed [15:0] pos_x,
    input  wire logic signed [15:0] pos_y,
    input  wire logic signed [14:0] heading,
    input  wire gtg_pkg::gtg_cmd_t  cmd,
    output gtg_pkg::gtg_sts_t       sts,
    output logic [15:0]             linear_cmd,
    output logic signed [15:0]      angular_cmd,
    output logic [1:0]              phase_now,
    output logic                    goal_reached
);
    import gtg_pkg::*;

    localparam int NI = (ITER > 24) ? 24 : ((ITER < 1) ? 1 : ITER);
    localparam logic [4:0] LAST = 5'(NI - 1);

    logic signed [15:0] goal_x_reg, goal_y_reg;
    logic [15:0] h_gain_reg, d_gain_reg, spd_lim_reg, d_tol_reg;
    logic [14:0] h_lim_reg;
    logic [13:0] h_tol_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            goal_x_reg  <= '0;
            goal_y_reg  <= '0;
            h_gain_reg  <= 16'd819;
            h_lim_reg   <= 15'd1229;
            h_tol_reg   <= 14'd205;
            d_gain_reg  <= 16'd1229;
            spd_lim_reg <= 16'd410;
            d_tol_reg   <= 16'd13;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_GOAL_X:  goal_x_reg  <= cfg_data;
                CFG_GOAL_Y:  goal_y_reg  <= cfg_data;
                CFG_H_GAIN:  h_gain_reg  <= cfg_data;
                CFG_H_LIM:   h_lim_reg   <= cfg_data[14:0];
                CFG_H_TOL:   h_tol_reg   <= cfg_data[13:0];
                CFG_D_GAIN:  d_gain_reg  <= cfg_data;
                CFG_SPD_LIM: spd_lim_reg <= cfg_data;
                CFG_D_TOL:   d_tol_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    // ---------------- CORDIC ----------------
    logic signed [XW-1:0] x_reg, y_reg;
    logic signed [ZW-1:0] z_reg;
    logic [4:0]  it_reg;
    logic        busy_reg, zero_reg, start_reg;
    logic signed [14:0] hd_reg;

    logic signed [16:0] dx, dy;
    logic signed [XW-1:0] xs0, ys0, sx, sy;
    assign dx  = 17'(goal_x_reg) - 17'(pos_x);
    assign dy  = 17'(goal_y_reg) - 17'(pos_y);
    assign xs0 = XW'(dx) <<< 8;
    assign ys0 = XW'(dy) <<< 8;
    assign sx  = x_reg >>> it_reg;
    assign sy  = y_reg >>> it_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            it_reg   <= '0;
        end
        else if (cmd.load)
        begin
            busy_reg <= 1'b1;
            it_reg   <= '0;
        end
        else if (busy_reg)
        begin
            if (it_reg == LAST)
                busy_reg <= 1'b0;
            else
                it_reg <= it_reg + 5'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            zero_reg  <= (dx == 0) && (dy == 0);
            start_reg <= start_goal;
            hd_reg    <= heading;
            if (dx < 0)
            begin
                if (dy >= 0)
                begin
                    x_reg <= ys0; y_reg <= -xs0; z_reg <= HALF_PI_Q16;
                end
                else
                begin
                    x_reg <= -ys0; y_reg <= xs0; z_reg <= -HALF_PI_Q16;
                end
            end
            else
            begin
                x_reg <= xs0; y_reg <= ys0; z_reg <= '0;
            end
        end
        else if (busy_reg)
        begin
            if (!y_reg[XW-1])
            begin
                x_reg <= x_reg + sy; y_reg <= y_reg - sx;
                z_reg <= z_reg + atan_q16(it_reg);
            end
            else
            begin
                x_reg <= x_reg - sy; y_reg <= y_reg + sx;
                z_reg <= z_reg - atan_q16(it_reg);
            end
        end
    end

    assign sts.cordic_done = busy_reg && (it_reg == LAST);

    // ---------------- post stage 1: scale and wrap ----------------
    logic [16:0] dist_reg;
    logic signed [16:0] err_reg;
    logic [XW+15:0] mprod;
    logic [XW+15:0] mround;
    logic signed [ZW+1:0] e0, e1;

    assign mprod  = XW'(x_reg) * INV_K_Q16;
    assign mround = (mprod + (60'(1) << 23)) >> 24;
    always_comb
    begin
        e0 = (zero_reg ? 22'sd0 : 22'(z_reg)) - (22'(hd_reg) <<< 4);
        if (e0 <= -22'(PI_Q16))
            e1 = e0 + 22'(TWO_PI_Q16);
        else if (e0 >= 22'(PI_Q16))
            e1 = e0 - 22'(TWO_PI_Q16);
        else
            e1 = e0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.post)
        begin
            dist_reg <= (mround > 60'(DIST_MAX)) ? DIST_MAX : mround[16:0];
            err_reg  <= 17'((e1 + 22'sd8) >>> 4);
        end
    end

    // ---------------- final stage: control law ----------------
    logic [1:0]  phase_reg;
    logic [16:0] prev_reg;
    logic        first_reg;

    logic [1:0]  ph_in;
    logic [16:0] emag;
    logic signed [34:0] aprod, ac;
    logic signed [34:0] lim;
    logic [32:0] lprod;
    logic [24:0] lr;
    logic signed [17:0] ddrop;
    logic        drive;

    logic [15:0]        lin_next;
    logic signed [15:0] ang_next;
    logic [1:0]         ph_now_next;
    logic               reached_next;

    assign ph_in = ((phase_reg == PH_IDLE || phase_reg == PH_DONE) && start_reg) ?
                   PH_ROT : phase_reg;
    assign emag  = err_reg[16] ? 17'(-err_reg) : 17'(err_reg);
    assign aprod = 35'(err_reg) * $signed({19'd0, h_gain_reg});
    assign ac    = (aprod + 35'sd2048) >>> 12;
    assign lim   = 35'($signed({1'b0, h_lim_reg}));
    assign lprod = 33'(d_gain_reg) * 33'(dist_reg);
    assign lr    = 25'((lprod + 33'd128) >> 8);
    assign ddrop = $signed({1'b0, prev_reg}) - $signed({1'b0, dist_reg});
    assign drive = first_reg || (dist_reg > 17'(d_tol_reg)) || (ddrop > 18'sd2);

    always_comb
    begin
        lin_next     = '0;
        ang_next     = '0;
        reached_next = 1'b0;
        ph_now_next  = ph_in;
        if (ph_in == PH_ROT)
        begin
            if (emag > 17'(h_tol_reg))
            begin
                if (ac > lim)
                    ang_next = 16'(lim);
                else if (ac < -lim)
                    ang_next = 16'(-lim);
                else
                    ang_next = 16'(ac);
            end
            else
                ph_now_next = PH_MOVE;
        end
        else if (ph_in == PH_MOVE)
        begin
            if (drive)
                lin_next = (lr > 25'(spd_lim_reg)) ? spd_lim_reg : lr[15:0];
            else
            begin
                ph_now_next  = PH_DONE;
                reached_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            prev_reg  <= '0;
            first_reg <= 1'b1;
        end
        else if (cmd.fin)
        begin
            phase_reg <= ph_now_next;
            if (ph_in == PH_ROT && emag <= 17'(h_tol_reg))
                first_reg <= 1'b1;
            else if (ph_in == PH_MOVE && drive)
            begin
                prev_reg  <= dist_reg;
                first_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.fin)
        begin
            linear_cmd   <= lin_next;
            angular_cmd  <= ang_next;
            goal_reached <= reached_next;
            phase_now    <= ph_now_next;
        end
    end

    a_no_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> !cmd.load) else $error("load while CORDIC busy");
    a_post_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.post |-> !busy_reg) else $error("post while CORDIC busy");
    a_done_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
        sts.cordic_done |=> !busy_reg) else $error("CORDIC did not stop");
endmodule
`default_nettype wire

// ----- rtl/go_to_goal_pose_controller.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// go_to_goal_pose_controller
// Two-phase proportional go-to-goal controller, one command word per pose word.
// ----------------------------------------------------------------------------
// Each pose word, once taken, produces one command word: the iterations of
// the shared vectoring CORDIC that yields both bearing and distance, the
// post-processing stage and the final control-law stage, then the command word
// is valid. One word is processed at a time; the CORDIC iteration loop sets the
// rate. A new pose word is taken in the same cycle the previous command word is
// taken.
module go_to_goal_pose_controller #(
    parameter int CORDIC_ITERATIONS = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [15:0] cfg_data,
    gtg_in_if.sink           pose,
    gtg_out_if.source        cmd_out
);
    import gtg_pkg::*;

    gtg_cmd_t cmd;
    gtg_sts_t sts;

    gtg_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (pose.valid),
        .in_ready  (pose.ready),
        .out_valid (cmd_out.valid),
        .out_ready (cmd_out.ready),
        .cmd       (cmd),
        .sts       (sts)
    );

    gtg_dp #(.ITER(CORDIC_ITERATIONS)) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .start_goal   (pose.start_goal),
        .pos_x        (pose.pos_x),
        .pos_y        (pose.pos_y),
        .heading      (pose.heading),
        .cmd          (cmd),
        .sts          (sts),
        .linear_cmd   (cmd_out.linear_cmd),
        .angular_cmd  (cmd_out.angular_cmd),
        .phase_now    (cmd_out.phase_now),
        .goal_reached (cmd_out.goal_reached)
    );
endmodule
`default_nettype wire
